>>> rtl/core/blim_pkg.sv
// Package for the bass and full-band peak limiter.
// Holds sample and gain widths, fixed-point constants and the channel,
// command and status structs used by the controller, datapath and top level.
package blim_pkg;

	localparam int SAMPLE_WIDTH = 24;
	localparam int FRAC_BITS = 20;

	localparam int GAIN_W = FRAC_BITS + 1;
	localparam int ENV_W = SAMPLE_WIDTH - 1;
	localparam int MAG_W = SAMPLE_WIDTH + 1;
	localparam int RATE_W = 32;
	localparam int NUM1_W = 2 * FRAC_BITS + 1;
	localparam int NUM_W = MAG_W + FRAC_BITS;
	localparam int DEN_W = SAMPLE_WIDTH;
	localparam int QUO_W = MAG_W;
	localparam int DSH_W = DEN_W + QUO_W - 1;
	localparam int CNT_W = $clog2(QUO_W + 1);

	localparam logic [GAIN_W-1:0] ONE_Q = GAIN_W'(1) << FRAC_BITS;
	localparam logic [ENV_W-1:0] SMP_MAX = {ENV_W{1'b1}};
	localparam logic [CNT_W-1:0] DIV1_STEPS = CNT_W'(GAIN_W);
	localparam logic [CNT_W-1:0] DIV2_STEPS = CNT_W'(QUO_W);
	localparam logic [RATE_W-1:0] BASS_RATE_RST = 32'd1825700;
	localparam logic [RATE_W-1:0] FULL_RATE_RST = 32'd29826;

	localparam logic CFG_BASS_RATE = 1'b0;
	localparam logic CFG_FULL_RATE = 1'b1;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] high_band;
		logic signed [SAMPLE_WIDTH-1:0] bass_mix;
	} blim_in_t;

	typedef struct packed {
		logic signed [SAMPLE_WIDTH-1:0] limited_sample;
		logic [GAIN_W-1:0] bass_gain_now;
	} blim_out_t;

	typedef struct packed {
		logic capture;
		logic prep;
		logic div_start;
		logic div_sel;
		logic gain;
		logic scale;
		logic env;
		logic load_out;
	} blim_cmd_t;

	typedef struct packed {
		logic need_div1;
		logic need_div2;
		logic div_busy;
		logic out_busy;
	} blim_stat_t;

endpackage

>>> rtl/core/blim_div.sv
// Iterative restoring divider for the limiter, one quotient bit per cycle.
// Uses widths from blim_pkg; the step count is given with each start.
module blim_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [blim_pkg::CNT_W-1:0]     steps,
	input  logic [blim_pkg::NUM_W-1:0]     num,
	input  logic [blim_pkg::DEN_W-1:0]     den,
	output logic                           busy,
	output logic [blim_pkg::QUO_W-1:0]     quot
);

	logic busy_q;
	logic [blim_pkg::CNT_W-1:0] cnt_q;
	logic [blim_pkg::DSH_W-1:0] rem_q;
	logic [blim_pkg::DSH_W-1:0] dsh_q;
	logic [blim_pkg::QUO_W-1:0] quo_q;
	logic fits;

	assign fits = rem_q >= dsh_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == blim_pkg::CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= blim_pkg::DSH_W'(num);
			dsh_q <= blim_pkg::DSH_W'(den) << (steps - 1'b1);
			quo_q <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - dsh_q;
			end
			dsh_q <= dsh_q >> 1;
			quo_q <= {quo_q[blim_pkg::QUO_W-2:0], fits};
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;

endmodule

>>> rtl/core/blim_datapath.sv
// Datapath of the limiter: configuration registers, gain and envelope
// state, arithmetic steps, the shared divider and the output register.
// Depends on blim_pkg and blim_div.
module blim_datapath (
	input  logic                  clk,
	input  logic                  arst_n,
	input  blim_pkg::blim_in_t    sample,
	input  logic                  cfg_we,
	input  logic                  cfg_index,
	input  logic [31:0]           cfg_data,
	input  blim_pkg::blim_cmd_t   cmd,
	output blim_pkg::blim_stat_t  stat,
	input  logic                  result_ready,
	output logic                  result_valid,
	output blim_pkg::blim_out_t   result
);

	localparam int SW = blim_pkg::SAMPLE_WIDTH;
	localparam int FB = blim_pkg::FRAC_BITS;

	logic [blim_pkg::RATE_W-1:0] bass_rate_q;
	logic [blim_pkg::RATE_W-1:0] full_rate_q;
	logic [blim_pkg::GAIN_W-1:0] gain_q;
	logic [blim_pkg::ENV_W-1:0] env_q;

	logic signed [SW-1:0] hb_s1;
	logic signed [SW-1:0] bm_s1;
	logic [SW-1:0] ah_q;
	logic [SW-1:0] ab_q;
	logic over_q;
	logic hfull_q;
	logic [blim_pkg::NUM1_W-1:0] num1_q;
	logic signed [SW:0] y_q;
	logic [blim_pkg::MAG_W-1:0] aout_q;
	logic out_valid_q;
	blim_pkg::blim_out_t out_q;

	logic signed [SW:0] h_ext;
	logic signed [SW:0] b_ext;
	logic signed [SW:0] h_abs;
	logic signed [SW:0] b_abs;
	logic signed [SW+1:0] sum_ext;
	logic signed [SW+1:0] sum_abs;
	logic [blim_pkg::GAIN_W-1:0] one_minus_ah;

	logic [blim_pkg::NUM_W-1:0] sat_lim;
	logic sat;
	logic [blim_pkg::GAIN_W-1:0] tgt;
	logic [blim_pkg::GAIN_W-1:0] g0;
	logic [blim_pkg::GAIN_W+blim_pkg::RATE_W-1:0] rel_prod;
	logic [blim_pkg::GAIN_W:0] g_rel;
	logic [blim_pkg::GAIN_W-1:0] g_new;

	logic [SW+blim_pkg::GAIN_W-1:0] bass_prod;
	logic signed [SW:0] scaled;
	logic signed [SW:0] y_new;

	logic [blim_pkg::MAG_W-1:0] aout;
	logic [blim_pkg::ENV_W-1:0] peak;
	logic [blim_pkg::ENV_W-1:0] env_gap;
	logic [blim_pkg::ENV_W+blim_pkg::RATE_W-1:0] env_prod;

	logic div_busy;
	logic [blim_pkg::QUO_W-1:0] quot;
	logic [blim_pkg::CNT_W-1:0] div_steps;
	logic [blim_pkg::NUM_W-1:0] div_num;
	logic [blim_pkg::DEN_W-1:0] div_den;

	logic [blim_pkg::MAG_W-1:0] out_mag;
	logic signed [SW-1:0] out_smp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bass_rate_q <= blim_pkg::BASS_RATE_RST;
			full_rate_q <= blim_pkg::FULL_RATE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				blim_pkg::CFG_BASS_RATE: bass_rate_q <= cfg_data;
				blim_pkg::CFG_FULL_RATE: full_rate_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign h_ext = {hb_s1[SW-1], hb_s1};
	assign b_ext = {bm_s1[SW-1], bm_s1};
	assign h_abs = hb_s1[SW-1] ? -h_ext : h_ext;
	assign b_abs = bm_s1[SW-1] ? -b_ext : b_ext;
	assign sum_ext = {h_ext[SW], h_ext} + {b_ext[SW], b_ext};
	assign sum_abs = sum_ext[SW+1] ? -sum_ext : sum_ext;
	assign one_minus_ah = blim_pkg::ONE_Q - h_abs[blim_pkg::GAIN_W-1:0];

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			hb_s1 <= sample.high_band;
			bm_s1 <= sample.bass_mix;
		end
		if (cmd.prep) begin
			ah_q <= h_abs[SW-1:0];
			ab_q <= b_abs[SW-1:0];
			over_q <= sum_abs > (SW+2)'(blim_pkg::ONE_Q);
			hfull_q <= h_abs >= (SW+1)'(blim_pkg::ONE_Q);
			num1_q <= {one_minus_ah, {FB{1'b0}}};
		end
	end

	// The quotient saturates at unity when num >= ab * (unity + 1).
	assign sat_lim = {ab_q, {FB{1'b0}}} + blim_pkg::NUM_W'(ab_q);
	assign sat = (ab_q == '0) || (blim_pkg::NUM_W'(num1_q) >= sat_lim);

	always_comb begin
		if (!over_q) begin
			tgt = blim_pkg::ONE_Q;
		end else if (hfull_q) begin
			tgt = '0;
		end else if (sat) begin
			tgt = blim_pkg::ONE_Q;
		end else begin
			tgt = quot[blim_pkg::GAIN_W-1:0];
		end
	end

	assign g0 = (gain_q > blim_pkg::ONE_Q) ? blim_pkg::ONE_Q : gain_q;
	assign rel_prod = (blim_pkg::ONE_Q - g0) * bass_rate_q;
	assign g_rel = {1'b0, g0} + (blim_pkg::GAIN_W+1)'(rel_prod >> blim_pkg::RATE_W);

	always_comb begin
		if (tgt < g0) begin
			g_new = tgt;
		end else if (g_rel > (blim_pkg::GAIN_W+1)'(blim_pkg::ONE_Q)) begin
			g_new = blim_pkg::ONE_Q;
		end else begin
			g_new = g_rel[blim_pkg::GAIN_W-1:0];
		end
	end

	assign bass_prod = ab_q * gain_q;
	assign scaled = $signed(bass_prod[SW+FB:FB]);
	assign y_new = h_ext + (bm_s1[SW-1] ? -scaled : scaled);

	assign aout = y_q[SW] ? blim_pkg::MAG_W'(-y_q) : blim_pkg::MAG_W'(y_q);
	assign peak = (aout > blim_pkg::MAG_W'(blim_pkg::SMP_MAX)) ? blim_pkg::SMP_MAX
		: aout[blim_pkg::ENV_W-1:0];
	assign env_gap = env_q - peak;
	assign env_prod = env_gap * full_rate_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= blim_pkg::ONE_Q;
			env_q <= '0;
		end else begin
			if (cmd.gain) begin
				gain_q <= g_new;
			end
			if (cmd.env) begin
				if (peak > env_q) begin
					env_q <= peak;
				end else begin
					env_q <= env_q - blim_pkg::ENV_W'(env_prod >> blim_pkg::RATE_W);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			y_q <= y_new;
		end
		if (cmd.env) begin
			aout_q <= aout;
		end
	end

	always_comb begin
		if (cmd.div_sel) begin
			div_steps = blim_pkg::DIV2_STEPS;
			div_num = {aout_q, {FB{1'b0}}};
			div_den = blim_pkg::DEN_W'(env_q);
		end else begin
			div_steps = blim_pkg::DIV1_STEPS;
			div_num = blim_pkg::NUM_W'(num1_q);
			div_den = ab_q;
		end
	end

	blim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.steps  (div_steps),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.quot   (quot)
	);

	assign out_mag = stat.need_div2 ? quot : aout_q;

	always_comb begin
		if (y_q[SW]) begin
			if (out_mag > (blim_pkg::MAG_W'(1) << (SW - 1))) begin
				out_smp = {1'b1, {(SW-1){1'b0}}};
			end else begin
				out_smp = $signed(SW'(~out_mag + 1'b1));
			end
		end else begin
			if (out_mag > blim_pkg::MAG_W'(blim_pkg::SMP_MAX)) begin
				out_smp = {1'b0, blim_pkg::SMP_MAX};
			end else begin
				out_smp = $signed(out_mag[SW-1:0]);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_q.limited_sample <= out_smp;
			out_q.bass_gain_now <= gain_q;
		end
	end

	assign stat.need_div1 = over_q && !hfull_q && !sat;
	assign stat.need_div2 = env_q > blim_pkg::ENV_W'(blim_pkg::ONE_Q);
	assign stat.div_busy = div_busy;
	assign stat.out_busy = out_valid_q && !result_ready;

	assign result_valid = out_valid_q;
	assign result = out_q;

endmodule

>>> rtl/core/blim_ctrl.sv
// Controller of the limiter: sequences the datapath steps for one sample.
// Depends on blim_pkg for the command and status structs.
module blim_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  sample_valid,
	output logic                  sample_ready,
	input  blim_pkg::blim_stat_t  stat,
	output blim_pkg::blim_cmd_t   cmd
);

	localparam logic [3:0] ST_IDLE  = 4'd0;
	localparam logic [3:0] ST_PREP  = 4'd1;
	localparam logic [3:0] ST_CHK1  = 4'd2;
	localparam logic [3:0] ST_DIV1  = 4'd3;
	localparam logic [3:0] ST_GAIN  = 4'd4;
	localparam logic [3:0] ST_SCALE = 4'd5;
	localparam logic [3:0] ST_ENV   = 4'd6;
	localparam logic [3:0] ST_CHK2  = 4'd7;
	localparam logic [3:0] ST_DIV2  = 4'd8;
	localparam logic [3:0] ST_OUT   = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		cmd = '0;
		sample_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				sample_ready = 1'b1;
				if (sample_valid) begin
					cmd.capture = 1'b1;
					state_d = ST_PREP;
				end
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d = ST_CHK1;
			end
			ST_CHK1: begin
				if (stat.need_div1) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV1;
				end else begin
					state_d = ST_GAIN;
				end
			end
			ST_DIV1: begin
				if (!stat.div_busy) begin
					state_d = ST_GAIN;
				end
			end
			ST_GAIN: begin
				cmd.gain = 1'b1;
				state_d = ST_SCALE;
			end
			ST_SCALE: begin
				cmd.scale = 1'b1;
				state_d = ST_ENV;
			end
			ST_ENV: begin
				cmd.env = 1'b1;
				state_d = ST_CHK2;
			end
			ST_CHK2: begin
				cmd.div_sel = 1'b1;
				if (stat.need_div2) begin
					cmd.div_start = 1'b1;
					state_d = ST_DIV2;
				end else begin
					state_d = ST_OUT;
				end
			end
			ST_DIV2: begin
				cmd.div_sel = 1'b1;
				if (!stat.div_busy) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				cmd.div_sel = 1'b1;
				if (!stat.out_busy) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/bass_and_fullband_peak_limiter.sv
// Top level of the bass and full-band peak limiter.
// Joins blim_ctrl and blim_datapath; types and constants come from blim_pkg.
//
// Usage: one transaction on the sample channel carries a high-band and a
// bass sample (signed Q4.20). One transaction on the result channel returns
// the limited sample and the bass gain after this sample's update.
// Both channels use valid and ready. The configuration port writes the bass
// and full-band release rates on any cycle with cfg_we high; write only
// while no sample is in flight.
// The block handles one sample at a time: it captures the sample, prepares
// the operands, runs a division for the bass target gain when one is needed,
// updates the gain, scales the bass, updates the envelope, runs a division
// by the envelope when it is above unity and then loads the result register.
// The next sample is accepted after the load. Both divisions share one restoring
// divider that makes one quotient bit per cycle.
// Reset clears the bass gain to unity, the envelope to zero, the rates to
// their defaults and the result register to empty. A stalled receiver holds
// the finished result; the next sample is still accepted and processed,
// and its result waits until the register is free.
module bass_and_fullband_peak_limiter (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	input  blim_pkg::blim_in_t   sample,
	output logic                 result_valid,
	input  logic                 result_ready,
	output blim_pkg::blim_out_t  result,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [31:0]          cfg_data
);

	blim_pkg::blim_cmd_t cmd;
	blim_pkg::blim_stat_t stat;

	blim_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_ready (sample_ready),
		.stat         (stat),
		.cmd          (cmd)
	);

	blim_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample       (sample),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.cmd          (cmd),
		.stat         (stat),
		.result_ready (result_ready),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for the bass and full-band peak limiter.
// Drives sample transactions and release-rate writes, predicts every result in
// a local fixed-point model and compares it field by field; depends on blim_pkg.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SAMPLE_WIDTH = blim_pkg::SAMPLE_WIDTH;
	localparam int FRAC_BITS = blim_pkg::FRAC_BITS;
	localparam int GAIN_W = blim_pkg::GAIN_W;
	localparam int LIMIT_CYCLES = 1000000;
	localparam int DRAIN_CYCLES = 80;
	localparam int N_DIRECTED = 21;
	localparam int N_PHASES = 6;
	localparam int PHASE_ITEMS = 238;
	localparam int UNITY_I = 1 << FRAC_BITS;
	localparam logic [63:0] UNITY = 64'd1 << FRAC_BITS;
	localparam logic [63:0] PEAK_MAX = (64'd1 << (SAMPLE_WIDTH - 1)) - 1;
	localparam longint OUT_MAX = (64'sd1 <<< (SAMPLE_WIDTH - 1)) - 1;
	localparam longint OUT_MIN = -OUT_MAX - 1;

	typedef struct {
		int hb;
		int bm;
		bit typed;
		int want_out;
		int want_gain;
	} directed_row_t;

	logic clk;
	logic arst_n;
	logic sample_valid;
	logic sample_ready;
	blim_pkg::blim_in_t sample;
	logic result_valid;
	logic result_ready;
	blim_pkg::blim_out_t result;
	logic cfg_we;
	logic cfg_index;
	logic [31:0] cfg_data;

	logic [63:0] model_bass_rate;
	logic [63:0] model_full_rate;
	logic [63:0] model_gain;
	logic [63:0] model_env;

	blim_pkg::blim_out_t pending_outputs[$];
	blim_pkg::blim_out_t want_out;
	int error_count = 0;
	int samples_sent = 0;
	int results_checked = 0;
	int gain_cuts = 0;
	int env_divisions = 0;
	int hold_request = 0;

	directed_row_t directed_rows [N_DIRECTED] = '{
		'{0, 0, 1'b1, 0, UNITY_I},
		'{524288, 0, 1'b1, 524288, UNITY_I},
		'{1048576, 1, 1'b1, 1048576, 0},
		'{1048577, 0, 1'b0, 0, 0},
		'{524288, 524289, 1'b0, 0, 0},
		'{786432, 524288, 1'b0, 0, 0},
		'{-786432, -524288, 1'b0, 0, 0},
		'{786432, -2097152, 1'b0, 0, 0},
		'{8388607, 8388607, 1'b0, 0, 0},
		'{-8388608, -8388608, 1'b0, 0, 0},
		'{8388607, -8388608, 1'b0, 0, 0},
		'{-8388608, 8388607, 1'b0, 0, 0},
		'{0, 8388607, 1'b0, 0, 0},
		'{0, -8388608, 1'b0, 0, 0},
		'{1048575, 2, 1'b0, 0, 0},
		'{-1048576, 0, 1'b0, 0, 0},
		'{0, 0, 1'b0, 0, 0},
		'{262144, 262144, 1'b0, 0, 0},
		'{-1, -1, 1'b0, 0, 0},
		'{8388607, 0, 1'b0, 0, 0},
		'{0, 0, 1'b0, 0, 0}
	};

	bass_and_fullband_peak_limiter dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_ready(sample_ready),
		.sample(sample),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT_CYCLES) @(posedge clk);
		$display("Timeout after %0d cycles with %0d results outstanding.",
			LIMIT_CYCLES, pending_outputs.size());
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic logic [63:0] magnitude(input longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	function automatic blim_pkg::blim_out_t limit_sample(input blim_pkg::blim_in_t s);
		longint h, b, y;
		logic [63:0] ah, ab, asum, tgt, g, scaled, aout, peak, q;
		blim_pkg::blim_out_t r;
		h = longint'($signed(s.high_band));
		b = longint'($signed(s.bass_mix));
		ah = magnitude(h);
		ab = magnitude(b);
		asum = magnitude(h + b);
		tgt = UNITY;
		if (asum > UNITY) begin
			if (ah >= UNITY) begin
				tgt = 0;
			end else if (ab != 0) begin
				q = ((UNITY - ah) << FRAC_BITS) / ab;
				tgt = (q > UNITY) ? UNITY : q;
			end
		end
		g = (model_gain > UNITY) ? UNITY : model_gain;
		if (tgt < g) begin
			g = tgt;
			gain_cuts++;
		end else begin
			g = g + (((UNITY - g) * model_bass_rate) >> 32);
		end
		if (g > UNITY) g = UNITY;
		model_gain = g;
		scaled = (ab * g) >> FRAC_BITS;
		y = (b < 0) ? h - longint'(scaled) : h + longint'(scaled);
		aout = magnitude(y);
		peak = (aout > PEAK_MAX) ? PEAK_MAX : aout;
		if (peak > model_env) begin
			model_env = peak;
		end else begin
			model_env = model_env - (((model_env - peak) * model_full_rate) >> 32);
		end
		if (model_env > UNITY) begin
			q = (aout * UNITY) / model_env;
			y = (y < 0) ? -longint'(q) : longint'(q);
			env_divisions++;
		end
		if (y > OUT_MAX) y = OUT_MAX;
		if (y < OUT_MIN) y = OUT_MIN;
		r.limited_sample = y[SAMPLE_WIDTH-1:0];
		r.bass_gain_now = g[GAIN_W-1:0];
		return r;
	endfunction

	function automatic int signed_range(input int m);
		return int'($urandom_range(0, 2 * m)) - m;
	endfunction

	function automatic int extreme_value();
		case ($urandom_range(0, 8))
			0: return -8388608;
			1: return 8388607;
			2: return 0;
			3: return UNITY_I;
			4: return -UNITY_I;
			5: return UNITY_I - 1;
			6: return -(UNITY_I - 1);
			7: return UNITY_I + 1;
			default: return -(UNITY_I + 1);
		endcase
	endfunction

	function automatic blim_pkg::blim_in_t random_sample();
		blim_pkg::blim_in_t s;
		int hv, bv;
		case ($urandom_range(0, 9))
			0, 1, 2: begin
				hv = int'($urandom);
				bv = int'($urandom);
			end
			3, 4, 5: begin
				hv = signed_range(943718);
				bv = signed_range(1572864);
			end
			6, 7: begin
				hv = signed_range(262144);
				bv = signed_range(262144);
			end
			8: begin
				hv = extreme_value();
				bv = extreme_value();
			end
			default: begin
				hv = signed_range(65536) + ($urandom_range(0, 1) ? UNITY_I : -UNITY_I);
				bv = signed_range(2097152);
			end
		endcase
		s.high_band = SAMPLE_WIDTH'(hv);
		s.bass_mix = SAMPLE_WIDTH'(bv);
		return s;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 90) return $urandom_range(1, 3);
		if (r < 98) return $urandom_range(4, 15);
		return $urandom_range(16, 80);
	endfunction

	task automatic flag_mismatch(input string what, input longint got, input longint want);
		$display("Mismatch in %s: got %0d, expected %0d.", what, got, want);
		error_count++;
	endtask

	task automatic send_sample(input blim_pkg::blim_in_t s, input bit typed,
		input blim_pkg::blim_out_t typed_out);
		blim_pkg::blim_out_t predicted;
		sample_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (!sample_ready) @(posedge clk);
		predicted = limit_sample(s);
		pending_outputs.push_back(typed ? typed_out : predicted);
		samples_sent++;
	endtask

	task automatic idle_sender(input int n);
		if (n > 0) begin
			sample_valid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	task automatic wait_drained();
		sample_valid <= 1'b0;
		do @(posedge clk); while (pending_outputs.size() != 0);
	endtask

	task automatic set_rates(input logic [31:0] bass_rate, input logic [31:0] full_rate);
		cfg_we <= 1'b1;
		cfg_index <= blim_pkg::CFG_BASS_RATE;
		cfg_data <= bass_rate;
		@(posedge clk);
		cfg_index <= blim_pkg::CFG_FULL_RATE;
		cfg_data <= full_rate;
		@(posedge clk);
		cfg_we <= 1'b0;
		model_bass_rate = 64'(bass_rate);
		model_full_rate = 64'(full_rate);
	endtask

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (pending_outputs.size() == 0) begin
				flag_mismatch("result with no sample pending",
					longint'($signed(result.limited_sample)), 0);
			end else begin
				want_out = pending_outputs.pop_front();
				if (result.limited_sample !== want_out.limited_sample)
					flag_mismatch("limited_sample", longint'($signed(result.limited_sample)),
						longint'($signed(want_out.limited_sample)));
				if (result.bass_gain_now !== want_out.bass_gain_now)
					flag_mismatch("bass_gain_now", longint'(result.bass_gain_now),
						longint'(want_out.bass_gain_now));
				results_checked++;
			end
		end
	end

	initial begin
		int stall;
		result_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_request > 0) begin
				stall = hold_request;
				hold_request = 0;
				result_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end else begin
				stall = pick_gap();
				if (stall > 0) begin
					result_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			result_ready <= 1'b1;
			repeat ($urandom_range(1, ($urandom_range(0, 19) == 0) ? 200 : 8)) @(posedge clk);
		end
	end

	initial begin
		logic [31:0] bass_rates [N_PHASES];
		logic [31:0] full_rates [N_PHASES];
		blim_pkg::blim_in_t s;
		blim_pkg::blim_out_t typed_out;
		int gap;

		arst_n = 1'b0;
		sample_valid = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = blim_pkg::CFG_BASS_RATE;
		cfg_data = '0;
		model_bass_rate = 64'(blim_pkg::BASS_RATE_RST);
		model_full_rate = 64'(blim_pkg::FULL_RATE_RST);
		model_gain = UNITY;
		model_env = 0;

		bass_rates[0] = blim_pkg::BASS_RATE_RST;
		full_rates[0] = blim_pkg::FULL_RATE_RST;
		bass_rates[1] = 32'd0;
		full_rates[1] = 32'd0;
		bass_rates[2] = 32'hFFFF_FFFF;
		full_rates[2] = 32'hFFFF_FFFF;
		bass_rates[3] = $urandom;
		full_rates[3] = $urandom;
		bass_rates[4] = 32'hFFFF_FFFF;
		full_rates[4] = 32'd0;
		bass_rates[5] = $urandom_range(0, 1 << 26);
		full_rates[5] = $urandom_range(0, 1 << 20);

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			s.high_band = SAMPLE_WIDTH'(directed_rows[i].hb);
			s.bass_mix = SAMPLE_WIDTH'(directed_rows[i].bm);
			typed_out.limited_sample = SAMPLE_WIDTH'(directed_rows[i].want_out);
			typed_out.bass_gain_now = GAIN_W'(directed_rows[i].want_gain);
			send_sample(s, directed_rows[i].typed, typed_out);
			idle_sender(pick_gap());
		end
		wait_drained();

		for (int p = 0; p < N_PHASES; p++) begin
			if (p != 0) set_rates(bass_rates[p], full_rates[p]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (p == 3 && n == 60) hold_request = 400;
				if (p == 4 && n == 100) wait_drained();
				send_sample(random_sample(), 1'b0, typed_out);
				gap = (((n / 50) % 5) == 2) ? 0 : pick_gap();
				idle_sender(gap);
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Sent %0d samples across %0d release-rate settings, zero and full scale included.",
			samples_sent, N_PHASES);
		$display("Checked %0d results: %0d bass gain cuts, %0d envelope-scaled outputs, %0d errors.",
			results_checked, gain_cuts, env_divisions, error_count);
		if (error_count == 0 && pending_outputs.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
